// ===== hw/rtl/itaf_pkg.sv =====
// Package for the integer to ASCII formatter: constants, flag bit positions,
// the job record passed from front to back, and the digit character function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package itaf_pkg;
  localparam int unsigned MaxFieldWidth = 63;
  localparam int unsigned ValueBits = 32;
  localparam int unsigned RadixMax = 36;
  localparam int unsigned FmtZero = 0;
  localparam int unsigned FmtLeft = 1;
  localparam int unsigned FmtPlus = 2;
  localparam int unsigned FmtSpace = 3;
  localparam int unsigned FmtUnsigned = 5;
  localparam int unsigned FmtCapital = 6;
  localparam int unsigned FmtNul = 7;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChPlus = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChSpace = 8'h20;

  typedef struct packed {
    logic        err;
    logic [31:0] mag;
    logic [5:0]  radix;
    logic [5:0]  width;
    logic        has_sign;
    logic [7:0]  sign;
    logic        left;
    logic        zero;
    logic        capital;
    logic        nul;
  } job_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic capital);
    logic [7:0] base;
    base = capital ? ChUpperA : ChLowerA;
    if (d > 6'd9) return base + {2'b00, d} - 8'd10;
    return ChZero + {2'b00, d};
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/itaf_front.sv =====
// Front part of the integer to ASCII formatter: takes input beats, checks the
// radix, derives sign and magnitude and hands a job record on. Uses itaf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module itaf_front #(
  parameter int unsigned MAX_FIELD_WIDTH = itaf_pkg::MaxFieldWidth,
  parameter int unsigned VALUE_BITS = itaf_pkg::ValueBits
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  wire [31:0]       value_i,
  input  wire [5:0]        field_width_i,
  input  wire [5:0]        radix_i,
  input  wire [7:0]        format_flags_i,
  output logic             job_valid_o,
  input  wire              job_ready_i,
  output itaf_pkg::job_t   job_o
);
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] neg;
  logic                  is_neg;
  itaf_pkg::job_t        job_d;
  itaf_pkg::job_t        job_q;
  logic                  valid_q;

  assign in_ready_o = !valid_q || job_ready_i;
  assign val = value_i[VALUE_BITS-1:0];
  assign neg = ~val + 1'b1;
  assign is_neg = !format_flags_i[itaf_pkg::FmtUnsigned] && val[VALUE_BITS-1];

  always_comb begin
    job_d = '0;
    job_d.err = (radix_i < 6'd2) || (radix_i > 6'(itaf_pkg::RadixMax));
    job_d.radix = radix_i;
    job_d.width = (field_width_i > 6'(MAX_FIELD_WIDTH)) ? 6'(MAX_FIELD_WIDTH)
                                                        : field_width_i;
    job_d.mag = 32'(is_neg ? neg : val);
    job_d.has_sign = 1'b1;
    if (is_neg) begin
      job_d.sign = itaf_pkg::ChMinus;
    end else if (format_flags_i[itaf_pkg::FmtPlus]) begin
      job_d.sign = itaf_pkg::ChPlus;
    end else if (format_flags_i[itaf_pkg::FmtSpace]) begin
      job_d.sign = itaf_pkg::ChSpace;
    end else begin
      job_d.has_sign = 1'b0;
    end
    job_d.left = format_flags_i[itaf_pkg::FmtLeft];
    job_d.zero = format_flags_i[itaf_pkg::FmtZero];
    job_d.capital = format_flags_i[itaf_pkg::FmtCapital];
    job_d.nul = format_flags_i[itaf_pkg::FmtNul];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      job_q <= job_d;
    end
  end

  assign job_valid_o = valid_q;
  assign job_o = job_q;
endmodule
`default_nettype wire

// ===== hw/rtl/itaf_queue.sv =====
// Two-entry job queue between the front and back parts of the formatter.
// Uses itaf_pkg for the job record.
`timescale 1ns / 1ps
`default_nettype none
module itaf_queue (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             wr_valid_i,
  output logic            wr_ready_o,
  input  itaf_pkg::job_t  wr_job_i,
  output logic            rd_valid_o,
  input  wire             rd_ready_i,
  output itaf_pkg::job_t  rd_job_o
);
  itaf_pkg::job_t mem_q [2];
  logic           wp_q;
  logic           rp_q;
  logic [1:0]     cnt_q;
  logic           wr;
  logic           rd;

  assign wr_ready_o = cnt_q != 2'd2;
  assign rd_valid_o = cnt_q != 2'd0;
  assign wr = wr_valid_i && wr_ready_o;
  assign rd = rd_valid_o && rd_ready_i;
  assign rd_job_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= !wp_q;
      if (rd) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= wr_job_i;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/itaf_divider.sv =====
// Bit-serial unsigned divider of a 32-bit magnitude by a 6-bit radix,
// one quotient bit per cycle. No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module itaf_divider (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         start_i,
  input  wire [31:0]  dividend_i,
  input  wire [5:0]   divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [5:0]  rem_o
);
  logic [31:0] q_q;
  logic [5:0]  r_q;
  logic [5:0]  dv_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic [6:0]  trial;
  logic        ge;

  assign trial = {r_q, q_q[31]};
  assign ge = trial >= {1'b0, dv_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      dv_q <= divisor_i;
    end else if (busy_q) begin
      q_q <= {q_q[30:0], ge};
      r_q <= 6'(ge ? trial - {1'b0, dv_q} : trial);
    end
  end

  assign quot_o = q_q;
  assign rem_o = r_q;
endmodule
`default_nettype wire

// ===== hw/rtl/itaf_back.sv =====
// Back part of the formatter: extracts digits with the serial divider into a
// digit store, then emits padding, sign, digits and terminator as beats; an
// invalid radix gives a single error beat instead. Uses itaf_pkg and itaf_divider.
`timescale 1ns / 1ps
`default_nettype none
module itaf_back (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             job_valid_i,
  output logic            job_ready_o,
  input  itaf_pkg::job_t  job_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output logic [7:0]      out_char_o,
  output logic            out_last_o,
  output logic            out_error_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StEmit = 3'd3;

  logic [2:0]     state_q;
  itaf_pkg::job_t job_q;
  logic [31:0]    mag_q;
  logic [7:0]     dig_q [32];
  logic [5:0]     ndig_q;
  logic [6:0]     pos_q;
  logic [6:0]     total_q;
  logic [6:0]     lead_q;
  logic [6:0]     zeros_q;
  logic           div_start;
  logic           div_done;
  logic [31:0]    quot;
  logic [5:0]     rem;
  logic [6:0]     w7;
  logic [6:0]     nd7;
  logic [6:0]     sg7;
  logic [6:0]     body;
  logic [6:0]     field;
  logic [6:0]     rel;
  logic [6:0]     di;
  logic [7:0]     ch;
  logic           last;
  logic           out_valid_q;
  logic [7:0]     out_char_q;
  logic           out_last_q;
  logic           out_error_q;
  logic           step;

  itaf_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag_q),
    .divisor_i  (job_q.radix),
    .done_o     (div_done),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  assign job_ready_o = state_q == StIdle;
  assign div_start = state_q == StDiv;
  assign w7 = {1'b0, job_q.width};
  assign nd7 = {1'b0, ndig_q};
  assign sg7 = {6'd0, job_q.has_sign};
  assign body = nd7 + sg7;
  assign field = (body > w7) ? body : w7;
  assign step = !out_valid_q || out_ready_i;

  always_comb begin
    rel = pos_q - lead_q;
    di = nd7 - 7'd1 - (rel - sg7 - zeros_q);
    ch = 8'd0;
    if (pos_q >= field) begin
      ch = 8'd0;
    end else if (pos_q < lead_q) begin
      ch = itaf_pkg::ChSpace;
    end else if (job_q.has_sign && rel == 7'd0) begin
      ch = job_q.sign;
    end else if (rel < sg7 + zeros_q) begin
      ch = itaf_pkg::ChZero;
    end else if (rel < body + zeros_q) begin
      ch = dig_q[di[4:0]];
    end else begin
      ch = itaf_pkg::ChSpace;
    end
    last = pos_q == total_q - 7'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      if (step) out_valid_q <= state_q == StEmit;
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            state_q <= job_i.err ? StEmit : StDiv;
          end
        end
        StDiv: state_q <= StWait;
        StWait: begin
          if (div_done) begin
            state_q <= (quot == 32'd0 || ndig_q == 6'd31) ? StEmit : StDiv;
          end
        end
        StEmit: begin
          if (step && (job_q.err || last)) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && job_valid_i) begin
      job_q <= job_i;
      mag_q <= job_i.mag;
      ndig_q <= '0;
      pos_q <= '0;
    end
    if (state_q == StWait && div_done) begin
      dig_q[ndig_q[4:0]] <= itaf_pkg::digit_char(rem, job_q.capital);
      ndig_q <= ndig_q + 6'd1;
      mag_q <= quot;
    end
    if (state_q == StWait && div_done) begin
      // Layout is fixed once the final digit count is known.
      lead_q <= (!job_q.left && !(job_q.zero && nd7 + 7'd1 < w7) &&
                 w7 > nd7 + 7'd1 + sg7) ? w7 - nd7 - 7'd1 - sg7 : 7'd0;
      zeros_q <= (!job_q.left && job_q.zero && nd7 + 7'd1 < w7 &&
                  w7 > nd7 + 7'd1 + sg7) ? w7 - nd7 - 7'd1 - sg7 : 7'd0;
      total_q <= ((nd7 + 7'd1 + sg7 > w7) ? nd7 + 7'd1 + sg7 : w7) +
                 {6'd0, job_q.nul};
    end
    if (state_q == StEmit && step) begin
      out_char_q <= job_q.err ? 8'd0 : ch;
      out_last_q <= job_q.err || last;
      out_error_q <= job_q.err;
      pos_q <= pos_q + 7'd1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o = out_char_q;
  assign out_last_o = out_last_q;
  assign out_error_o = out_error_q;
endmodule
`default_nettype wire

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Top level of the printf-style integer to ASCII formatter.
// Instantiates itaf_front, itaf_queue and itaf_back; uses itaf_pkg.
//
// Channel | Direction | tdata (low to high)                           | tuser | tlast
// s_axis  | in        | value, field_width, radix, format_flags       | -     | -
// m_axis  | out       | out_char                                      | error | last
//
// For each digit the back part starts the divider, lets it work through all 32
// magnitude bits and stores the remainder as a character, then emits the characters;
// an invalid radix skips the divider and goes straight to a single error beat.
// The front accepts further numbers into a two-entry queue while the back works.
// Reset is asynchronous and active low and clears all control state.
// The output register holds a beat until m_axis_tready is seen.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_ascii_formatter #(
  parameter int unsigned MAX_FIELD_WIDTH = itaf_pkg::MaxFieldWidth,
  parameter int unsigned VALUE_BITS = itaf_pkg::ValueBits
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        s_axis_tvalid,
  output logic       s_axis_tready,
  input  wire [55:0] s_axis_tdata,  // value[31:0], field_width, radix, format_flags
  output logic       m_axis_tvalid,
  input  wire        m_axis_tready,
  output logic [7:0] m_axis_tdata,  // out_char
  output logic       m_axis_tuser,  // error
  output logic       m_axis_tlast
);
  logic           f_valid;
  logic           f_ready;
  itaf_pkg::job_t f_job;
  logic           q_valid;
  logic           q_ready;
  itaf_pkg::job_t q_job;

  itaf_front #(
    .MAX_FIELD_WIDTH (MAX_FIELD_WIDTH),
    .VALUE_BITS      (VALUE_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .value_i        (s_axis_tdata[31:0]),
    .field_width_i  (s_axis_tdata[37:32]),
    .radix_i        (s_axis_tdata[43:38]),
    .format_flags_i (s_axis_tdata[51:44]),
    .job_valid_o    (f_valid),
    .job_ready_i    (f_ready),
    .job_o          (f_job)
  );

  itaf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_job_i   (f_job),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_job_o   (q_job)
  );

  itaf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_error_o (m_axis_tuser)
  );

  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 8'd0)
    else $error("error beat must be a single last NUL");
  a_queue_hs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready |=> !q_ready)
    else $error("back took a job while busy");
endmodule
`default_nettype wire

// ===== bench/integer_to_ascii_formatter_tb.sv =====
// Self-checking bench for the printf-style integer to ASCII formatter.
// Drives numbers on s_axis, predicts every character and compares on m_axis.
// Depends on itaf_pkg and integer_to_ascii_formatter.
`timescale 1ns / 1ps
module integer_to_ascii_formatter_tb;
  typedef struct packed {
    logic [7:0]  flags;
    logic [5:0]  radix;
    logic [5:0]  width;
    logic [31:0] value;
  } number_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       err;
    logic       last;
  } char_t;

  localparam int unsigned WatchdogLimit = 40000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  number_t pending_numbers[$];
  char_t   expected_chars[$];
  int      mismatch_count = 0;
  int      send_gap = 0;
  int      recv_gap = 0;
  int      hold_off = 0;
  logic    pause_sender = 1'b0;
  int      idle_cycles = 0;

  integer_to_ascii_formatter uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .m_axis_tlast(m_axis_tlast)
  );

  always #4 clk_i = ~clk_i;

  function automatic void format_number(input number_t n);
    logic [7:0]  text[$];
    logic [7:0]  digits[$];
    logic [31:0] mag;
    logic [7:0]  sign_ch;
    logic [7:0]  rem;
    logic [7:0]  letter;
    bit          has_sign;
    bit          zero_pad;
    int          w;
    int          pad;
    has_sign = 1'b0;
    sign_ch = itaf_pkg::ChSpace;
    if (n.radix < 2 || n.radix > itaf_pkg::RadixMax) begin
      expected_chars.push_back('{ch: 8'h00, err: 1'b1, last: 1'b1});
      return;
    end
    w = (n.width > itaf_pkg::MaxFieldWidth) ? itaf_pkg::MaxFieldWidth : n.width;
    mag = n.value;
    if (!n.flags[itaf_pkg::FmtUnsigned] && n.value[31]) begin
      mag = -n.value;
      sign_ch = itaf_pkg::ChMinus;
      has_sign = 1'b1;
    end else if (n.flags[itaf_pkg::FmtPlus]) begin
      sign_ch = itaf_pkg::ChPlus;
      has_sign = 1'b1;
    end else if (n.flags[itaf_pkg::FmtSpace]) begin
      has_sign = 1'b1;
    end
    letter = n.flags[itaf_pkg::FmtCapital] ? itaf_pkg::ChUpperA : itaf_pkg::ChLowerA;
    do begin
      rem = 8'(mag % n.radix);
      mag = mag / n.radix;
      digits.push_front(rem > 9 ? letter + rem - 8'd10 : itaf_pkg::ChZero + rem);
    end while (mag != 0);
    zero_pad = n.flags[itaf_pkg::FmtZero] && (digits.size() < w);
    if (n.flags[itaf_pkg::FmtLeft]) begin
      if (has_sign) text.push_back(sign_ch);
      foreach (digits[i]) text.push_back(digits[i]);
      while (text.size() < w) text.push_back(itaf_pkg::ChSpace);
    end else if (zero_pad) begin
      if (has_sign) text.push_back(sign_ch);
      while (text.size() < w - digits.size()) text.push_back(itaf_pkg::ChZero);
      foreach (digits[i]) text.push_back(digits[i]);
    end else begin
      pad = w - digits.size() - (has_sign ? 1 : 0);
      while (text.size() < pad) text.push_back(itaf_pkg::ChSpace);
      if (has_sign) text.push_back(sign_ch);
      foreach (digits[i]) text.push_back(digits[i]);
    end
    if (n.flags[itaf_pkg::FmtNul]) text.push_back(8'h00);
    foreach (text[i])
      expected_chars.push_back('{ch: text[i], err: 1'b0, last: i == text.size() - 1});
  endfunction

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 20);
      1: return -$urandom_range(1, 20);
      2: return 32'h8000_0000 ^ $urandom_range(0, 1);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic number_t random_number();
    number_t n;
    n.value = random_value();
    n.width = ($urandom_range(0, 9) == 0) ? 6'($urandom) : 6'($urandom_range(0, 16));
    if ($urandom_range(0, 15) == 0) n.radix = 6'($urandom_range(0, 1));
    else if ($urandom_range(0, 15) == 0) n.radix = 6'($urandom_range(37, 63));
    else n.radix = 6'($urandom_range(2, 36));
    n.flags = 8'($urandom);
    return n;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        format_number(number_t'(s_axis_tdata[51:0]));
        void'(pending_numbers.pop_front());
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        s_axis_tvalid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_numbers.size() > 0 && !pause_sender) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= 56'(pending_numbers[0]);
        send_gap <= $urandom_range(0, 19);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_chars.size() == 0) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 10) $display("unexpected beat: char %h", m_axis_tdata);
        end else begin
          if ({m_axis_tdata, m_axis_tuser, m_axis_tlast} != expected_chars[0]) begin
            mismatch_count <= mismatch_count + 1;
            if (mismatch_count < 10)
              $display("mismatch: expected char %h err %b last %b, got %h %b %b",
                       expected_chars[0].ch, expected_chars[0].err, expected_chars[0].last,
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
          end
          void'(expected_chars.pop_front());
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (recv_gap > 0) begin
          recv_gap = recv_gap - 1;
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= 1'b1;
        end
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_numbers.size() != 0 || s_axis_tvalid || expected_chars.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    number_t n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    pending_numbers.push_back('{value: 32'd0, width: 6'd0, radix: 6'd10, flags: 8'h00});
    pending_numbers.push_back('{value: 32'h8000_0000, width: 6'd0, radix: 6'd10, flags: 8'h00});
    pending_numbers.push_back('{value: 32'h8000_0000, width: 6'd0, radix: 6'd2, flags: 8'h20});
    pending_numbers.push_back('{value: 32'hFFFF_FFFF, width: 6'd0, radix: 6'd2, flags: 8'h20});
    pending_numbers.push_back('{value: 32'hFFFF_FFFF, width: 6'd63, radix: 6'd36, flags: 8'h01});
    pending_numbers.push_back('{value: 32'hDEAD_BEEF, width: 6'd12, radix: 6'd16, flags: 8'h60});
    pending_numbers.push_back('{value: 32'hDEAD_BEEF, width: 6'd12, radix: 6'd16, flags: 8'h21});
    pending_numbers.push_back('{value: 32'd42, width: 6'd8, radix: 6'd10, flags: 8'h04});
    pending_numbers.push_back('{value: 32'd42, width: 6'd8, radix: 6'd10, flags: 8'h08});
    pending_numbers.push_back('{value: 32'd42, width: 6'd8, radix: 6'd10, flags: 8'h05});
    pending_numbers.push_back('{value: -32'd42, width: 6'd8, radix: 6'd10, flags: 8'h03});
    pending_numbers.push_back('{value: -32'd42, width: 6'd8, radix: 6'd10, flags: 8'h81});
    pending_numbers.push_back('{value: 32'd12345, width: 6'd3, radix: 6'd10, flags: 8'h01});
    pending_numbers.push_back('{value: 32'd7, width: 6'd0, radix: 6'd0, flags: 8'h00});
    pending_numbers.push_back('{value: 32'd7, width: 6'd0, radix: 6'd1, flags: 8'h00});
    pending_numbers.push_back('{value: 32'd7, width: 6'd0, radix: 6'd37, flags: 8'h00});
    pending_numbers.push_back('{value: 32'd7, width: 6'd5, radix: 6'd63, flags: 8'hFF});
    pending_numbers.push_back('{value: 32'd35, width: 6'd0, radix: 6'd36, flags: 8'h10});
    pending_numbers.push_back('{value: 32'd0, width: 6'd63, radix: 6'd8, flags: 8'h8A});
    wait_drained();
    hold_off <= 400;
    for (int i = 0; i < 150; i++) pending_numbers.push_back(random_number());
    wait_drained();
    pause_sender <= 1'b1;
    repeat (30) @(posedge clk_i);
    pause_sender <= 1'b0;
    for (int i = 0; i < 150; i++) begin
      n = random_number();
      pending_numbers.push_back(n);
    end
    wait_drained();
    repeat (200) @(posedge clk_i);
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/itaf_pkg.sv
hw/rtl/itaf_front.sv
hw/rtl/itaf_queue.sv
hw/rtl/itaf_divider.sv
hw/rtl/itaf_back.sv
hw/rtl/integer_to_ascii_formatter.sv
bench/integer_to_ascii_formatter_tb.sv
